>>> design/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/u2u8_pkg.sv
// Types, constants and encoding helpers for the UTF-16 to UTF-8 text filter.
`default_nettype none

package u2u8_pkg;

   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE  = 21'h10000;
   localparam logic [15:0] PRIV_FIRST = 16'hF700;
   localparam logic [15:0] PRIV_LAST  = 16'hF8FF;
   localparam logic [15:0] DEL_CODE   = 16'h007F;
   localparam logic [15:0] SPACE_CODE = 16'h0020;
   localparam logic [7:0]  LEAD2      = 8'hC0;
   localparam logic [7:0]  LEAD3      = 8'hE0;
   localparam logic [7:0]  LEAD4      = 8'hF0;
   localparam logic [7:0]  CONT       = 8'h80;

   localparam logic [5:0]  HIGH_TAG   = 6'b110110;

   localparam logic [1:0]  STAT_TEXT        = 2'd0;
   localparam logic [1:0]  STAT_NO_OUTPUT   = 2'd1;
   localparam logic [1:0]  STAT_UNAVAILABLE = 2'd2;

   // At most one job per accepted word: an optional held or combined code point,
   // an optional fresh code point and an optional status-only result.
   typedef struct packed {
      logic        a_valid;
      logic [20:0] a_cp;
      logic        b_valid;
      logic [15:0] b_cp;
      logic        s_valid;
      logic [1:0]  s_code;
      logic        mark_last;
   } job_type;

   typedef enum logic [2:0] {
      SEG_A = 3'b001,
      SEG_B = 3'b010,
      SEG_S = 3'b100
   } seg_type;

   function automatic logic is_text(input logic [15:0] cp);
      logic ok;
      ok = 1'b1;
      if (cp < SPACE_CODE || cp == DEL_CODE) ok = 1'b0;
      if (cp >= PRIV_FIRST && cp <= PRIV_LAST) ok = 1'b0;
      return ok;
   endfunction

   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] len;
      if (cp < 21'h80) len = 3'd1;
      else if (cp < 21'h800) len = 3'd2;
      else if (cp < SUPP_BASE) len = 3'd3;
      else len = 3'd4;
      return len;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
      logic [7:0] b;
      case (utf8_len(cp))
         3'd1: b = {1'b0, cp[6:0]};
         3'd2: begin
            case (idx)
               2'd0:    b = LEAD2 | {3'b000, cp[10:6]};
               default: b = CONT | {2'b00, cp[5:0]};
            endcase
         end
         3'd3: begin
            case (idx)
               2'd0:    b = LEAD3 | {4'b0000, cp[15:12]};
               2'd1:    b = CONT | {2'b00, cp[11:6]};
               default: b = CONT | {2'b00, cp[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = LEAD4 | {5'b00000, cp[20:18]};
               2'd1:    b = CONT | {2'b00, cp[17:12]};
               2'd2:    b = CONT | {2'b00, cp[11:6]};
               default: b = CONT | {2'b00, cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

>>> design/utf16_to_utf8_text_filter_unit.sv
// A word's first result passes through the job queue, the serializer's job register
// and its output register. Throughput: one result per cycle from the serializer while
// results are popped, and a word causes zero to six results; one with none pushes no job.
// The job queue lets the input keep taking words while the serializer drains earlier ones.
// Reset is synchronous and active high; it empties the queue and clears surrogate state.
`default_nettype none

module utf16_to_utf8_text_filter_unit #(
   parameter int JOB_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_kind,
   input  wire logic [15:0] req_code_unit,
   input  wire logic        req_final_unit,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_byte_out,
   output logic             rsp_byte_valid,
   output logic             rsp_run_last,
   output logic [1:0]       rsp_status
);
   import u2u8_pkg::*;

   job_type front_job, head_job;
   logic    front_push, job_pop, job_empty, accept;

   assign accept = req_push && !req_full;

   u2u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_kind),
      .code_unit  (req_code_unit),
      .final_unit (req_final_unit),
      .job        (front_job),
      .job_push   (front_push)
   );

   u2u8_job_fifo #(
      .DEPTH (JOB_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_job (front_job),
      .pop      (job_pop),
      .head_job (head_job),
      .full     (req_full),
      .empty    (job_empty)
   );

   u2u8_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .job_empty      (job_empty),
      .job_pop        (job_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

>>> design/u2u8_front.sv
// Front end: accepts code units, tracks surrogate and failure state, builds jobs.
`default_nettype none

module u2u8_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              kind,
   input  wire logic [15:0]       code_unit,
   input  wire logic              final_unit,
   output u2u8_pkg::job_type      job,
   output logic                   job_push
);
   import u2u8_pkg::*;

   logic [9:0] held_high_ff, held_high_in;
   logic       held_valid_ff, held_valid_in;
   logic       run_failed_ff, run_failed_in;

   always_comb begin
      logic fresh;
      logic is_low;
      logic is_high;
      fresh = 1'b1;
      is_low  = (code_unit >= LOW_FIRST) && (code_unit <= LOW_LAST);
      is_high = (code_unit >= HIGH_FIRST) && (code_unit <= HIGH_LAST);
      job = '0;
      held_high_in  = held_high_ff;
      held_valid_in = held_valid_ff;
      run_failed_in = run_failed_ff;
      if (accept) begin
         if (kind) begin
            job.s_valid   = 1'b1;
            job.s_code    = STAT_NO_OUTPUT;
            held_high_in  = '0;
            held_valid_in = 1'b0;
            run_failed_in = 1'b0;
         end else if (run_failed_ff) begin
            if (final_unit) begin
               job.s_valid   = 1'b1;
               job.s_code    = STAT_UNAVAILABLE;
               held_high_in  = '0;
               held_valid_in = 1'b0;
               run_failed_in = 1'b0;
            end
         end else begin
            if (held_valid_ff) begin
               held_valid_in = 1'b0;
               held_high_in  = '0;
               job.a_valid   = 1'b1;
               if (is_low) begin
                  job.a_cp = SUPP_BASE + {1'b0, held_high_ff, code_unit[9:0]};
                  fresh    = 1'b0;
               end else begin
                  job.a_cp = {5'b00000, HIGH_TAG, held_high_ff};
               end
            end
            if (fresh) begin
               if (is_high && !final_unit) begin
                  held_high_in  = code_unit[9:0];
                  held_valid_in = 1'b1;
               end else if (!is_text(code_unit)) begin
                  if (final_unit) begin
                     job.s_valid   = 1'b1;
                     job.s_code    = STAT_UNAVAILABLE;
                     held_high_in  = '0;
                     held_valid_in = 1'b0;
                     run_failed_in = 1'b0;
                  end else begin
                     run_failed_in = 1'b1;
                  end
               end else begin
                  job.b_valid = 1'b1;
                  job.b_cp    = code_unit;
                  if (final_unit) begin
                     job.mark_last = 1'b1;
                     held_high_in  = '0;
                     held_valid_in = 1'b0;
                     run_failed_in = 1'b0;
                  end
               end
            end else if (final_unit) begin
               job.mark_last = 1'b1;
               held_high_in  = '0;
               held_valid_in = 1'b0;
               run_failed_in = 1'b0;
            end
         end
      end
      job_push = accept && (job.a_valid || job.b_valid || job.s_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_high_ff  <= '0;
         held_valid_ff <= 1'b0;
         run_failed_ff <= 1'b0;
      end else begin
         held_high_ff  <= held_high_in;
         held_valid_ff <= held_valid_in;
         run_failed_ff <= run_failed_in;
      end
   end

endmodule

`default_nettype wire

>>> design/u2u8_job_fifo.sv
// Short job queue between the front end and the byte serializer.
`default_nettype none

module u2u8_job_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire u2u8_pkg::job_type push_job,
   input  wire logic              pop,
   output u2u8_pkg::job_type      head_job,
   output logic                   full,
   output logic                   empty
);
   import u2u8_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> design/u2u8_back.sv
// Back end: walks each job and emits one UTF-8 byte or status word per cycle while its output is free or popped.
`default_nettype none

module u2u8_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire u2u8_pkg::job_type head_job,
   input  wire logic              job_empty,
   output logic                   job_pop,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output logic [7:0]             rsp_byte_out,
   output logic                   rsp_byte_valid,
   output logic                   rsp_run_last,
   output logic [1:0]             rsp_status
);
   import u2u8_pkg::*;

   job_type     job_ff, job_in;
   seg_type     seg_ff, seg_in;
   logic [1:0]  idx_ff, idx_in;
   logic        busy_ff, busy_in;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_bvalid_ff, out_bvalid_in;
   logic        out_last_ff, out_last_in;
   logic [1:0]  out_status_ff, out_status_in;

   logic        can_emit, emit, done, load_new;
   logic [2:0]  len_a, len_b;
   logic        more_bytes;
   seg_type     next_seg, start_seg;
   logic        has_next;

   assign can_emit = !out_valid_ff || rsp_pop;
   assign emit     = busy_ff && can_emit;
   assign len_a    = utf8_len(job_ff.a_cp);
   assign len_b    = utf8_len({5'b00000, job_ff.b_cp});

   always_comb begin
      more_bytes = 1'b0;
      next_seg   = SEG_S;
      has_next   = 1'b0;
      case (seg_ff)
         SEG_A: begin
            more_bytes = ({1'b0, idx_ff} + 3'd1) < len_a;
            if (job_ff.b_valid) begin
               next_seg = SEG_B;
               has_next = 1'b1;
            end else if (job_ff.s_valid) begin
               next_seg = SEG_S;
               has_next = 1'b1;
            end
         end
         SEG_B: begin
            more_bytes = ({1'b0, idx_ff} + 3'd1) < len_b;
            if (job_ff.s_valid) begin
               next_seg = SEG_S;
               has_next = 1'b1;
            end
         end
         default: begin
            more_bytes = 1'b0;
            has_next   = 1'b0;
         end
      endcase
      done = !more_bytes && !has_next;
   end

   always_comb begin
      if (head_job.a_valid) start_seg = SEG_A;
      else if (head_job.b_valid) start_seg = SEG_B;
      else start_seg = SEG_S;
   end

   assign load_new = !busy_ff || (emit && done);
   assign job_pop  = load_new && !job_empty;

   always_comb begin
      job_in  = job_ff;
      seg_in  = seg_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (emit && !done) begin
         if (more_bytes) begin
            idx_in = idx_ff + 1'b1;
         end else begin
            seg_in = next_seg;
            idx_in = '0;
         end
      end
      if (load_new) begin
         busy_in = !job_empty;
         job_in  = head_job;
         seg_in  = start_seg;
         idx_in  = '0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         case (seg_ff)
            SEG_A: begin
               out_byte_in   = utf8_byte(job_ff.a_cp, idx_ff);
               out_bvalid_in = 1'b1;
               out_last_in   = done && job_ff.mark_last;
               out_status_in = STAT_TEXT;
            end
            SEG_B: begin
               out_byte_in   = utf8_byte({5'b00000, job_ff.b_cp}, idx_ff);
               out_bvalid_in = 1'b1;
               out_last_in   = done && job_ff.mark_last;
               out_status_in = STAT_TEXT;
            end
            default: begin
               out_byte_in   = '0;
               out_bvalid_in = 1'b0;
               out_last_in   = 1'b1;
               out_status_in = job_ff.s_code;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= SEG_A;
         idx_ff       <= '0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_byte_out   = out_byte_ff;
   assign rsp_byte_valid = out_bvalid_ff;
   assign rsp_run_last   = out_last_ff;
   assign rsp_status     = out_status_ff;

endmodule

`default_nettype wire

>>> design/u2u8_checker.sv
// Port-level checks for the text filter, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module u2u8_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [7:0]  rsp_byte_out,
   input wire logic        rsp_byte_valid,
   input wire logic        rsp_run_last,
   input wire logic [1:0]  rsp_status
);
   import u2u8_pkg::*;

   // A waiting result stays put until it is popped.
   `ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_byte_out) && $stable(rsp_byte_valid) && $stable(rsp_run_last) && $stable(rsp_status))

   // Status is only carried on the closing word of a run.
   `ASSERT_IMPLY(a_status_zero, clock, reset, !rsp_empty && !rsp_run_last, rsp_status == STAT_TEXT)

   // A status-only word always closes a run with a non-text status.
   `ASSERT_IMPLY(a_status_only, clock, reset, !rsp_empty && !rsp_byte_valid, rsp_run_last && (rsp_status == STAT_NO_OUTPUT || rsp_status == STAT_UNAVAILABLE))

   // A byte that closes a run reports plain text.
   `ASSERT_IMPLY(a_text_close, clock, reset, !rsp_empty && rsp_byte_valid && rsp_run_last, rsp_status == STAT_TEXT)

endmodule

bind utf16_to_utf8_text_filter_unit u2u8_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_byte_out   (rsp_byte_out),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_run_last   (rsp_run_last),
   .rsp_status     (rsp_status)
);

`default_nettype wire

>>> sim/utf16_to_utf8_text_filter_check.sv
// Checker for the UTF-16 to UTF-8 text filter: predicts each word's bytes and compares results.
`timescale 1ns / 1ps

module utf16_to_utf8_text_filter_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic        req_full,
   input  wire logic        req_kind,
   input  wire logic [15:0] req_code_unit,
   input  wire logic        req_final_unit,
   input  wire logic        rsp_empty,
   input  wire logic        rsp_pop,
   input  wire logic [7:0]  rsp_byte_out,
   input  wire logic        rsp_byte_valid,
   input  wire logic        rsp_run_last,
   input  wire logic [1:0]  rsp_status,
   output int               mismatch_count,
   output int               bytes_pending
);
   import u2u8_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       last;
      logic [1:0] status;
   } utf8_result_type;

   utf8_result_type expected_bytes[$];

   // Transcoder state kept by the predictor.
   logic [9:0] held_high = '0;
   logic       held_valid = 1'b0;
   logic       run_failed = 1'b0;

   int errors = 0;
   int waiting = 0;

   assign mismatch_count = errors;
   assign bytes_pending  = waiting;

   function automatic logic printable(input logic [15:0] cp);
      return !(cp < SPACE_CODE || cp == DEL_CODE || (cp >= PRIV_FIRST && cp <= PRIV_LAST));
   endfunction

   task automatic push_result(input logic [7:0] data, input logic has_byte,
                              input logic last, input logic [1:0] status);
      utf8_result_type r;
      r.data = data;
      r.has_byte = has_byte;
      r.last = last;
      r.status = status;
      expected_bytes.insert(expected_bytes.size(), r);
   endtask

   task automatic push_utf8(input logic [20:0] cp);
      if (cp < 21'h80) begin
         push_result({1'b0, cp[6:0]}, 1'b1, 1'b0, STAT_TEXT);
      end else if (cp < 21'h800) begin
         push_result(LEAD2 | {3'b000, cp[10:6]}, 1'b1, 1'b0, STAT_TEXT);
         push_result(CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0, STAT_TEXT);
      end else if (cp < SUPP_BASE) begin
         push_result(LEAD3 | {4'b0000, cp[15:12]}, 1'b1, 1'b0, STAT_TEXT);
         push_result(CONT | {2'b00, cp[11:6]}, 1'b1, 1'b0, STAT_TEXT);
         push_result(CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0, STAT_TEXT);
      end else begin
         push_result(LEAD4 | {5'b00000, cp[20:18]}, 1'b1, 1'b0, STAT_TEXT);
         push_result(CONT | {2'b00, cp[17:12]}, 1'b1, 1'b0, STAT_TEXT);
         push_result(CONT | {2'b00, cp[11:6]}, 1'b1, 1'b0, STAT_TEXT);
         push_result(CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0, STAT_TEXT);
      end
   endtask

   task automatic clear_run();
      held_high = '0;
      held_valid = 1'b0;
      run_failed = 1'b0;
   endtask

   task automatic transcode_word(input logic kind, input logic [15:0] unit, input logic fin);
      int first;
      logic paired;
      first = expected_bytes.size();
      paired = 1'b0;
      if (kind) begin
         // An empty key press abandons whatever run is open.
         clear_run();
         push_result(8'h00, 1'b0, 1'b1, STAT_NO_OUTPUT);
         return;
      end
      if (run_failed) begin
         if (fin) begin
            clear_run();
            push_result(8'h00, 1'b0, 1'b1, STAT_UNAVAILABLE);
         end
         return;
      end
      if (held_valid) begin
         held_valid = 1'b0;
         if (unit >= LOW_FIRST && unit <= LOW_LAST) begin
            push_utf8(SUPP_BASE + {1'b0, held_high, unit[9:0]});
            paired = 1'b1;
         end else begin
            push_utf8({5'd0, HIGH_FIRST | {6'd0, held_high}});
         end
         held_high = '0;
      end
      if (!paired) begin
         if (unit >= HIGH_FIRST && unit <= HIGH_LAST && !fin) begin
            held_high = unit[9:0];
            held_valid = 1'b1;
            return;
         end
         if (!printable(unit)) begin
            if (fin) begin
               clear_run();
               push_result(8'h00, 1'b0, 1'b1, STAT_UNAVAILABLE);
            end else begin
               run_failed = 1'b1;
            end
            return;
         end
         push_utf8({5'd0, unit});
      end
      if (fin) begin
         clear_run();
         if (expected_bytes.size() > first) begin
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
            expected_bytes[expected_bytes.size() - 1].status = STAT_TEXT;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      utf8_result_type want;
      if (reset) begin
         clear_run();
         expected_bytes.delete();
      end else begin
         // A word's job passes through the job queue and the serializer's registers before its
         // results show, so the result side can be checked before this cycle's input word is predicted.
         if (rsp_pop && !rsp_empty) begin
            if (expected_bytes.size() == 0) begin
               if (errors < 10)
                  $display("unexpected word: byte %02h valid %b last %b status %0d",
                           rsp_byte_out, rsp_byte_valid, rsp_run_last, rsp_status);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_byte_out !== want.data || rsp_byte_valid !== want.has_byte ||
                   rsp_run_last !== want.last || rsp_status !== want.status) begin
                  if (errors < 10)
                     $display("mismatch: expected byte %02h valid %b last %b status %0d, %s",
                              want.data, want.has_byte, want.last, want.status,
                              $sformatf("got byte %02h valid %b last %b status %0d",
                                        rsp_byte_out, rsp_byte_valid, rsp_run_last,
                                        rsp_status));
                  errors++;
               end
            end
         end
         if (req_push && !req_full)
            transcode_word(req_kind, req_code_unit, req_final_unit);
      end
      waiting = expected_bytes.size();
   end

endmodule

>>> sim/tb_utf16_to_utf8_text_filter_unit.sv
// Testbench top for the UTF-16 to UTF-8 text filter: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_utf16_to_utf8_text_filter_unit;
   import u2u8_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_kind = 1'b0;
   logic [15:0] req_code_unit = '0;
   logic        req_final_unit = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_byte_out;
   logic        rsp_byte_valid;
   logic        rsp_run_last;
   logic [1:0]  rsp_status;

   int mismatch_count;
   int bytes_pending;
   int words_sent = 0;
   int pop_hold = 0;
   bit quiet = 1'b0;   // no random idling on either side
   bit steady = 1'b0;  // a stretch without idling

   always #5 clock = ~clock;

   utf16_to_utf8_text_filter_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_code_unit  (req_code_unit),
      .req_final_unit (req_final_unit),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_status     (rsp_status)
   );

   utf16_to_utf8_text_filter_check u_transcode_check (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_code_unit  (req_code_unit),
      .req_final_unit (req_final_unit),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_status     (rsp_status),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending)
   );

   // Result side: pop stalls come in random bursts.
   always @(negedge clock) begin
      if (quiet) begin
         rsp_pop <= 1'b1;
      end else if (pop_hold > 0) begin
         rsp_pop <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
         rsp_pop <= 1'b0;
         pop_hold <= $urandom_range(0, 15);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Called at a falling edge; returns at a falling edge after the word is taken.
   task automatic send_word(input logic kind, input logic [15:0] unit, input logic fin);
      req_push <= 1'b1;
      req_kind <= kind;
      req_code_unit <= unit;
      req_final_unit <= fin;
      @(posedge clock);
      while (req_full) @(posedge clock);
      words_sent++;
      @(negedge clock);
      if (!quiet && !steady && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (bytes_pending != 0) @(negedge clock);
   endtask

   // One key press run that is mostly well-formed text with random content.
   task automatic send_random_run();
      int len;
      int k;
      logic fin;
      len = $urandom_range(1, 5);
      for (k = 0; k < len; k++) begin
         fin = (k == len - 1);
         case ($urandom_range(0, 9))
            0, 1, 2: send_word(1'b0, 16'($urandom_range(16'h0020, 16'h007E)), fin);
            3:       send_word(1'b0, 16'($urandom_range(16'h0080, 16'h07FF)), fin);
            4:       send_word(1'b0, 16'($urandom_range(16'h0800, 16'hFFFF)), fin);
            5, 6: begin
               send_word(1'b0, HIGH_FIRST | 16'($urandom_range(0, 1023)), 1'b0);
               send_word(1'b0, LOW_FIRST | 16'($urandom_range(0, 1023)), fin);
            end
            7:       send_word(1'b0, HIGH_FIRST | 16'($urandom_range(0, 2047)), fin);
            8:       send_word(1'b0, 16'($urandom), fin);
            default: begin
               case ($urandom_range(0, 5))
                  0:       send_word(1'b0, 16'($urandom_range(0, 16'h001F)), fin);
                  1:       send_word(1'b0, DEL_CODE, fin);
                  2:       send_word(1'b0, 16'($urandom_range(PRIV_FIRST, PRIV_LAST)), fin);
                  default: send_word(1'b0, 16'($urandom_range(16'h0020, 16'h007E)), fin);
               endcase
            end
         endcase
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words: an empty press, and the one-, two- and three-byte encoding boundaries.
      send_word(1'b1, 16'hFFFF, 1'b1);
      send_word(1'b0, SPACE_CODE, 1'b0);
      send_word(1'b0, 16'h007E, 1'b0);
      send_word(1'b0, 16'h0080, 1'b0);
      send_word(1'b0, 16'h07FF, 1'b0);
      send_word(1'b0, 16'h0800, 1'b0);
      send_word(1'b0, 16'hFFFF, 1'b1);
      // Surrogate pairs at both ends of the supplementary range.
      send_word(1'b0, HIGH_FIRST, 1'b0);
      send_word(1'b0, LOW_FIRST, 1'b1);
      send_word(1'b0, HIGH_LAST, 1'b0);
      send_word(1'b0, LOW_LAST, 1'b1);
      // A held high surrogate followed by plain text, then by another high.
      send_word(1'b0, 16'hD83D, 1'b0);
      send_word(1'b0, 16'h0041, 1'b0);
      send_word(1'b0, HIGH_FIRST, 1'b0);
      send_word(1'b0, 16'hD801, 1'b0);
      send_word(1'b0, 16'hDC05, 1'b1);
      // A high surrogate that ends a run, and a lone low surrogate.
      send_word(1'b0, HIGH_LAST, 1'b1);
      send_word(1'b0, LOW_FIRST, 1'b1);
      // Failure behind a held surrogate, then the rest of the failed run.
      send_word(1'b0, HIGH_FIRST, 1'b0);
      send_word(1'b0, DEL_CODE, 1'b0);
      send_word(1'b0, 16'h0061, 1'b1);
      // Failing units that end a run, and private-use edges.
      send_word(1'b0, 16'h0000, 1'b1);
      send_word(1'b0, PRIV_FIRST, 1'b1);
      send_word(1'b0, 16'hF6FF, 1'b0);
      send_word(1'b0, PRIV_LAST, 1'b1);
      // An empty press abandons an open run with a held surrogate.
      send_word(1'b0, HIGH_LAST, 1'b0);
      send_word(1'b1, 16'h0000, 1'b0);
      wait_drained();
      @(negedge clock);

      while (words_sent < 420) begin
         if (words_sent > 350) quiet = 1'b1;
         if ($urandom_range(0, 15) == 0) steady = !steady;
         case ($urandom_range(0, 19))
            0, 1:   send_word(1'b1, 16'($urandom), 1'($urandom));
            2, 3:   send_word(1'($urandom_range(0, 3) == 0), 16'($urandom), 1'($urandom));
            4: begin
               if ($urandom_range(0, 3) == 0) begin
                  wait_drained();
                  @(negedge clock);
               end else begin
                  send_random_run();
               end
            end
            default: send_random_run();
         endcase
      end

      req_push <= 1'b0;
      while (bytes_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && bytes_pending == 0) begin
         $display("tb_utf16_to_utf8_text_filter_unit OK");
      end else begin
         $display("tb_utf16_to_utf8_text_filter_unit NOT OK");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_utf16_to_utf8_text_filter_unit NOT OK");
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/u2u8_pkg.sv
design/u2u8_front.sv
design/u2u8_job_fifo.sv
design/u2u8_back.sv
design/utf16_to_utf8_text_filter_unit.sv
design/u2u8_checker.sv
sim/utf16_to_utf8_text_filter_check.sv
sim/tb_utf16_to_utf8_text_filter_unit.sv
